@@ design/urbe_pkg.sv @@
// ----------------------------------------------------------------------------
// urbe_pkg
// Shared types and constants for the UART ring buffer engine.
// ----------------------------------------------------------------------------
package urbe_pkg;

   // default queue depths (each queue holds depth minus one bytes)
   localparam int RX_DEPTH_DEF = 32;
   localparam int TX_DEPTH_DEF = 32;

   // characters handled by the host write path
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   // result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // operation codes of a request word
   typedef enum logic [1:0] {
      KIND_RX       = 2'd0,
      KIND_READ     = 2'd1,
      KIND_WRITE    = 2'd2,
      KIND_TX_READY = 2'd3
   } kind_type;

   // request word
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } req_word_type;

   // response word
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] read_data;
      logic       send_strobe;
      logic [7:0] send_byte;
      logic       sender_running;
      logic       start_transmit;
   } rsp_word_type;

endpackage

@@ design/uart_ring_buffer_engine_core.sv @@
// ----------------------------------------------------------------------------
// uart_ring_buffer_engine_core
// Receive and transmit byte queues held in two RAMs, driven by request words.
// ----------------------------------------------------------------------------
// A response word is registered out of the data state that follows an accepted request.
// A new request is not accepted while busy; busy is high for the one cycle in
//   which the registered RAM read returns the queued byte.
// A line feed write stores its trailing carriage return in the following data cycle.
// Reset (synchronous): clears all queue indexes and the transmitter enable;
//   the queue RAMs are not cleared and need no clearing pass.
module uart_ring_buffer_engine_core
   import urbe_pkg::*;
#(
   parameter int RX_DEPTH = RX_DEPTH_DEF,
   parameter int TX_DEPTH = TX_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_strobe,
   output rsp_word_type rsp_word
);

   localparam int RX_IW = $clog2(RX_DEPTH);
   localparam int TX_IW = $clog2(TX_DEPTH);
   localparam int TX_CW = TX_IW + 1;

   typedef enum logic {
      S_IDLE,
      S_DATA
   } state_type;

   state_type      state_ff, state_in;
   logic [RX_IW-1:0] rx_wr_ff, rx_wr_in, rx_rd_ff, rx_rd_in;
   logic [TX_IW-1:0] tx_wr_ff, tx_wr_in, tx_rd_ff, tx_rd_in;
   logic           tx_en_ff, tx_en_in;
   logic [1:0]     status_ff, status_in;
   logic           read_ok_ff, read_ok_in;
   logic           send_ff, send_in;
   logic           start_tx_ff, start_tx_in;
   logic           cr_pend_ff, cr_pend_in;
   logic [TX_IW-1:0] cr_addr_ff, cr_addr_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type   rsp_word_ff, rsp_word_in;

   logic             accept;
   logic [RX_IW-1:0] rx_wr_nxt, rx_rd_nxt;
   logic [TX_IW-1:0] tx_wr_nxt1, tx_wr_nxt2, tx_rd_nxt;
   logic [TX_CW-1:0] tx_cnt, tx_room, tx_need;
   logic             is_lf;

   logic             rx_we, rx_re, tx_we, tx_re;
   logic [RX_IW-1:0] rx_wa;
   logic [TX_IW-1:0] tx_wa;
   logic [7:0]       tx_wd, rx_rdata, tx_rdata;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   // advance indexes with wrap at the queue depth
   assign rx_wr_nxt  = (rx_wr_ff == RX_IW'(RX_DEPTH - 1)) ? '0 : rx_wr_ff + RX_IW'(1);
   assign rx_rd_nxt  = (rx_rd_ff == RX_IW'(RX_DEPTH - 1)) ? '0 : rx_rd_ff + RX_IW'(1);
   assign tx_wr_nxt1 = (tx_wr_ff == TX_IW'(TX_DEPTH - 1)) ? '0 : tx_wr_ff + TX_IW'(1);
   assign tx_wr_nxt2 = (tx_wr_nxt1 == TX_IW'(TX_DEPTH - 1)) ? '0 : tx_wr_nxt1 + TX_IW'(1);
   assign tx_rd_nxt  = (tx_rd_ff == TX_IW'(TX_DEPTH - 1)) ? '0 : tx_rd_ff + TX_IW'(1);

   // free room in the transmit queue
   assign tx_cnt  = (tx_wr_ff >= tx_rd_ff)
                  ? ({1'b0, tx_wr_ff} - {1'b0, tx_rd_ff})
                  : ({1'b0, tx_wr_ff} + TX_CW'(TX_DEPTH) - {1'b0, tx_rd_ff});
   assign tx_room = TX_CW'(TX_DEPTH - 1) - tx_cnt;
   assign is_lf   = (req_word.data == CHAR_LF);
   assign tx_need = is_lf ? TX_CW'(2) : TX_CW'(1);

   // decode the request, update indexes, steer RAM accesses
   always_comb begin
      state_in      = state_ff;
      rx_wr_in      = rx_wr_ff;
      rx_rd_in      = rx_rd_ff;
      tx_wr_in      = tx_wr_ff;
      tx_rd_in      = tx_rd_ff;
      tx_en_in      = tx_en_ff;
      status_in     = status_ff;
      read_ok_in    = read_ok_ff;
      send_in       = send_ff;
      start_tx_in   = start_tx_ff;
      cr_pend_in    = cr_pend_ff;
      cr_addr_in    = cr_addr_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      rx_we         = 1'b0;
      rx_wa         = rx_wr_nxt;
      rx_re         = 1'b0;
      tx_we         = 1'b0;
      tx_wa         = tx_wr_nxt1;
      tx_wd         = req_word.data;
      tx_re         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in    = S_DATA;
               status_in   = ST_DONE;
               read_ok_in  = 1'b0;
               send_in     = 1'b0;
               start_tx_in = 1'b0;
               unique case (req_word.kind)
                  KIND_RX: begin
                     if (rx_wr_nxt != rx_rd_ff) begin
                        rx_we    = 1'b1;
                        rx_wr_in = rx_wr_nxt;
                     end else begin
                        status_in = ST_FULL;
                     end
                  end
                  KIND_READ: begin
                     if (rx_wr_ff == rx_rd_ff) begin
                        status_in = ST_EMPTY;
                     end else begin
                        rx_re      = 1'b1;
                        rx_rd_in   = rx_rd_nxt;
                        read_ok_in = 1'b1;
                     end
                  end
                  KIND_WRITE: begin
                     if (tx_room < tx_need) begin
                        status_in = ST_FULL;
                     end else begin
                        tx_we = 1'b1;
                        if (is_lf) begin
                           cr_pend_in = 1'b1;
                           cr_addr_in = tx_wr_nxt2;
                           tx_wr_in   = tx_wr_nxt2;
                        end else begin
                           tx_wr_in = tx_wr_nxt1;
                        end
                        if (!tx_en_ff) begin
                           tx_en_in    = 1'b1;
                           start_tx_in = 1'b1;
                        end
                     end
                  end
                  KIND_TX_READY: begin
                     if (tx_en_ff) begin
                        if (tx_wr_ff != tx_rd_ff) begin
                           tx_re    = 1'b1;
                           tx_rd_in = tx_rd_nxt;
                           send_in  = 1'b1;
                        end else begin
                           tx_en_in = 1'b0;
                        end
                     end
                  end
               endcase
            end
         end
         S_DATA: begin
            // store the carriage return that follows a line feed
            if (cr_pend_ff) begin
               tx_we      = 1'b1;
               tx_wa      = cr_addr_ff;
               tx_wd      = CHAR_CR;
               cr_pend_in = 1'b0;
            end
            rsp_word_in.status         = status_ff;
            rsp_word_in.read_data      = read_ok_ff ? rx_rdata : 8'd0;
            rsp_word_in.send_strobe    = send_ff;
            rsp_word_in.send_byte      = send_ff ? tx_rdata : 8'd0;
            rsp_word_in.sender_running = tx_en_ff;
            rsp_word_in.start_transmit = start_tx_ff;
            rsp_strobe_in              = 1'b1;
            state_in                   = S_IDLE;
         end
      endcase
   end

   // hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rx_wr_ff      <= '0;
         rx_rd_ff      <= '0;
         tx_wr_ff      <= '0;
         tx_rd_ff      <= '0;
         tx_en_ff      <= 1'b0;
         cr_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rx_wr_ff      <= rx_wr_in;
         rx_rd_ff      <= rx_rd_in;
         tx_wr_ff      <= tx_wr_in;
         tx_rd_ff      <= tx_rd_in;
         tx_en_ff      <= tx_en_in;
         cr_pend_ff    <= cr_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      status_ff   <= status_in;
      read_ok_ff  <= read_ok_in;
      send_ff     <= send_in;
      start_tx_ff <= start_tx_in;
      cr_addr_ff  <= cr_addr_in;
      rsp_word_ff <= rsp_word_in;
   end

   // receive queue storage
   urbe_ram #(
      .WIDTH (8),
      .DEPTH (RX_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_we),
      .wr_addr (rx_wa),
      .wr_data (req_word.data),
      .rd_en   (rx_re),
      .rd_addr (rx_rd_nxt),
      .rd_data (rx_rdata)
   );

   // transmit queue storage
   urbe_ram #(
      .WIDTH (8),
      .DEPTH (TX_DEPTH)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_we),
      .wr_addr (tx_wa),
      .wr_data (tx_wd),
      .rd_en   (tx_re),
      .rd_addr (tx_rd_nxt),
      .rd_data (tx_rdata)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // every accepted request yields a response word once its data state has passed
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe)
      else $error("response word missing after accepted request");

   // a pending carriage return is only stored in the data cycle
   a_cr_in_data: assert property (@(posedge clock) disable iff (reset)
      cr_pend_ff |-> (state_ff == S_DATA))
      else $error("carriage return pending outside data cycle");

   // a byte sent implies the transmitter is still running
   a_send_running: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.send_strobe) |-> rsp_word.sender_running)
      else $error("byte sent while transmitter stopped");

   // a start of transmission reports a running transmitter and done status
   a_start_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.start_transmit)
         |-> (rsp_word.sender_running && (rsp_word.status == ST_DONE)))
      else $error("start of transmission with bad status");

   // no response word while a request is being worked on
   a_no_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("response word while busy");

endmodule

@@ design/urbe_ram.sv @@
// ----------------------------------------------------------------------------
// urbe_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module urbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one entry, register the read entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
